@@ rtl/dfs_topological_sort_core_macros.svh @@
// Assertion macros used by the back end of the graph sort core.
`ifndef DFS_TOPOLOGICAL_SORT_CORE_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define DFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfs core check failed");

// Next-cycle implication, checked on every clock outside reset.
`define DFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfs core check failed");

`endif

@@ rtl/dfs_pkg.sv @@
// Shared types and constants of the graph sort core.
package dfs_pkg;

    localparam int P_MAX_NODES = 32;
    localparam int P_NODE_W    = 5;
    localparam int P_CMP_W     = 8;

    localparam logic [1:0] KIND_EDGE    = 2'd0;
    localparam logic [1:0] KIND_NODE    = 2'd1;
    localparam logic [1:0] KIND_NOT_DAG = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_SORT   = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_REMOVE,
        OP_QUERY,
        OP_SORT,
        OP_ERROR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [P_NODE_W-1:0] from_node;
        logic [P_NODE_W-1:0] to_node;
    } t_cmd;

    typedef struct packed {
        logic [1:0]          kind;
        logic [P_NODE_W-1:0] node;
        logic                edge_present;
        logic                last;
    } t_result;

endpackage

@@ rtl/dfs_topological_sort_core.sv @@
// Top level of the graph sort core: ports, node count register and the two halves.
//
// Graph core holding a directed graph as a bit adjacency matrix of MAX_NODES
// nodes, cleared at reset. Each input word adds, removes or queries one edge, or
// asks for a depth-first topological sort of the first node_count nodes. Each edge
// word returns one word. A sort runs one step of the search per cycle: it tries
// each start node in turn and ends the root scan, follows each edge, finishes each
// node and returns from each search tree, then emits the sorted nodes one by one.
// The single search sequencer reads one adjacency row per cycle. A two-entry
// command queue lets the front end keep accepting words until the queue is full
// while the back end works or the output stalls.
module dfs_topological_sort_core
    import dfs_pkg::*;
#(
    parameter int MAX_NODES = P_MAX_NODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,   // node_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata, // from_node[4:0], to_node[9:5], zero fill
    input  logic [1:0]  s_axis_tuser, // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata, // node[4:0], edge_present[5], zero fill
    output logic [1:0]  m_axis_tuser, // kind[1:0]
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(MAX_NODES + 1);

    logic [5:0]    r_node_count;
    logic [CW-1:0] eff_n;
    logic          cmd_valid;
    logic          cmd_ready;
    t_cmd          cmd;
    t_result       result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 6'd32;
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_node_count == 6'd0) begin
            eff_n = CW'(1);
        end else if (P_CMP_W'(r_node_count) > P_CMP_W'(MAX_NODES)) begin
            eff_n = CW'(MAX_NODES);
        end else begin
            eff_n = CW'(r_node_count);
        end
    end

    dfs_front #(.MAX_NODES(MAX_NODES), .CW(CW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (eff_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_from_node  (s_axis_tdata[4:0]),
        .i_to_node    (s_axis_tdata[9:5]),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    dfs_back #(.MAX_NODES(MAX_NODES), .CW(CW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (eff_n),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = {2'b00, result.edge_present, result.node};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

@@ rtl/dfs_front.sv @@
// Front end: accepts words, checks node indices and queues commands for the back end.
module dfs_front
    import dfs_pkg::*;
#(
    parameter int MAX_NODES = P_MAX_NODES,
    parameter int CW        = $clog2(MAX_NODES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CW-1:0]       i_node_count,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_action,
    input  logic [P_NODE_W-1:0] i_from_node,
    input  logic [P_NODE_W-1:0] i_to_node,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output t_cmd                o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;
    logic       bad_index;

    always_comb begin
        bad_index = (P_CMP_W'(i_from_node) >= P_CMP_W'(i_node_count)) ||
                    (P_CMP_W'(i_to_node) >= P_CMP_W'(i_node_count));
        n_cmd.from_node = i_from_node;
        n_cmd.to_node   = i_to_node;
        case (i_action)
            ACT_ADD:    n_cmd.op = bad_index ? OP_ERROR : OP_ADD;
            ACT_REMOVE: n_cmd.op = bad_index ? OP_ERROR : OP_REMOVE;
            ACT_QUERY:  n_cmd.op = bad_index ? OP_ERROR : OP_QUERY;
            ACT_SORT:   n_cmd.op = OP_SORT;
            default:    n_cmd.op = OP_ERROR;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ rtl/dfs_back.sv @@
// Back end: adjacency matrix, edge edits and the depth-first sort sequencer.
module dfs_back
    import dfs_pkg::*;
#(
    parameter int MAX_NODES = P_MAX_NODES,
    parameter int CW        = $clog2(MAX_NODES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_node_count,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  t_cmd          i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output t_result       o_result
);
    `include "dfs_topological_sort_core_macros.svh"

    localparam int NW = $clog2(MAX_NODES);

    localparam logic [1:0] WHITE = 2'd0;
    localparam logic [1:0] GRAY  = 2'd1;
    localparam logic [1:0] BLACK = 2'd2;

    typedef enum logic [2:0] {S_IDLE, S_ROOT, S_WALK, S_FAIL, S_EMIT} t_state;

    t_state               r_state;
    logic [MAX_NODES-1:0] r_adj   [MAX_NODES];
    logic [1:0]           r_color [MAX_NODES];
    logic [CW-1:0]        r_scan  [MAX_NODES];
    logic [NW-1:0]        r_stack [MAX_NODES];
    logic [NW-1:0]        r_fin   [MAX_NODES];
    logic [CW-1:0]        r_sp;
    logic [CW-1:0]        r_fc;
    logic [CW-1:0]        r_root;
    logic [NW-1:0]        r_emit;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 out_free;
    logic [NW-1:0]        from_i;
    logic [NW-1:0]        to_i;
    logic [NW-1:0]        root_i;
    logic [NW-1:0]        u;
    logic [MAX_NODES-1:0] cand;
    logic                 v_found;
    logic [NW-1:0]        v;

    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign from_i      = NW'(i_cmd.from_node);
    assign to_i        = NW'(i_cmd.to_node);
    assign root_i      = NW'(r_root);
    assign u           = r_stack[NW'(r_sp - CW'(1))];

    // Next neighbor of the node on top of the stack, lowest index first.
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            cand[j] = r_adj[u][j] && (CW'(j) >= r_scan[u]) && (CW'(j) < i_node_count);
        end
        v_found = 1'b0;
        v       = '0;
        for (int j = MAX_NODES - 1; j >= 0; j--) begin
            if (cand[j]) begin
                v_found = 1'b1;
                v       = NW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_fc        <= '0;
            r_root      <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) r_adj[i] <= '0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && out_free) begin
                        r_out.kind         <= KIND_EDGE;
                        r_out.node         <= '0;
                        r_out.edge_present <= 1'b0;
                        r_out.last         <= 1'b1;
                        case (i_cmd.op)
                            OP_ADD: begin
                                r_adj[from_i][to_i] <= 1'b1;
                                r_out_valid         <= 1'b1;
                            end
                            OP_REMOVE: begin
                                r_adj[from_i][to_i] <= 1'b0;
                                r_out_valid         <= 1'b1;
                            end
                            OP_QUERY: begin
                                r_out.edge_present <= r_adj[from_i][to_i];
                                r_out_valid        <= 1'b1;
                            end
                            OP_SORT: begin
                                for (int i = 0; i < MAX_NODES; i++) r_color[i] <= WHITE;
                                r_sp    <= '0;
                                r_fc    <= '0;
                                r_root  <= '0;
                                r_state <= S_ROOT;
                            end
                            default: begin
                                r_out.kind  <= KIND_ERROR;
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_ROOT: begin
                    if (r_root == i_node_count) begin
                        r_emit  <= NW'(r_fc - CW'(1));
                        r_state <= S_EMIT;
                    end else begin
                        r_root <= r_root + CW'(1);
                        if (r_color[root_i] == WHITE) begin
                            r_color[root_i] <= GRAY;
                            r_scan[root_i]  <= '0;
                            r_stack[0]      <= root_i;
                            r_sp            <= CW'(1);
                            r_state         <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_sp == '0) begin
                        r_state <= S_ROOT;
                    end else if (!v_found) begin
                        r_color[u]       <= BLACK;
                        r_fin[NW'(r_fc)] <= u;
                        r_fc             <= r_fc + CW'(1);
                        r_sp             <= r_sp - CW'(1);
                    end else begin
                        r_scan[u] <= CW'(v) + CW'(1);
                        if (r_color[v] == WHITE) begin
                            r_color[v]         <= GRAY;
                            r_scan[v]          <= '0;
                            r_stack[NW'(r_sp)] <= v;
                            r_sp               <= r_sp + CW'(1);
                        end else if (r_color[v] == GRAY) begin
                            r_sp    <= '0;
                            r_state <= S_FAIL;
                        end
                    end
                end
                S_FAIL: begin
                    if (out_free) begin
                        r_out.kind         <= KIND_NOT_DAG;
                        r_out.node         <= '0;
                        r_out.edge_present <= 1'b0;
                        r_out.last         <= 1'b1;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.kind         <= KIND_NODE;
                        r_out.node         <= P_NODE_W'(r_fin[r_emit]);
                        r_out.edge_present <= 1'b0;
                        r_out.last         <= (r_emit == '0);
                        r_out_valid        <= 1'b1;
                        r_emit             <= r_emit - NW'(1);
                        if (r_emit == '0) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DFS_ASSERT_NOW(a_stack_bound, 1'b1, r_sp <= CW'(MAX_NODES))
    `DFS_ASSERT_NOW(a_idle_empty_stack, r_state == S_IDLE, r_sp == '0)
    `DFS_ASSERT_NEXT(a_emit_done, r_state == S_EMIT && out_free && r_emit == '0,
        r_state == S_IDLE && r_out_valid && r_out.last)
    `DFS_ASSERT_NOW(a_finish_bound, r_state != S_IDLE, r_fc <= i_node_count)

endmodule
